FILE: rtl/pld_pkg.sv
package pld_pkg;

   localparam int MAX_LINES    = 16;
   localparam int LINE_BITS    = 4;
   localparam int COUNT_BITS   = 5;
   localparam int PROB_BITS    = 24;
   localparam int CUM_BITS     = PROB_BITS + 1;
   localparam int ENERGY_BITS  = 32;
   localparam int UNI_BITS     = 24;
   localparam int DIR_FRAC     = 16;
   localparam int DIR_BITS     = DIR_FRAC + 2;
   localparam int CSR_BITS     = 25;
   localparam int CORDIC_STEPS = 30;
   localparam int SQRT_STEPS   = 31;
   localparam int RAD_BITS     = 61;
   localparam int CW           = 34;
   localparam int PROD_BITS    = 66;
   localparam int ROUND_SHIFT  = 60 - DIR_FRAC;

   localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

   localparam logic [31:0] TURN_ATAN [CORDIC_STEPS] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
      32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
      32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
      32'd20, 32'd10, 32'd5, 32'd3, 32'd1
   };

   typedef enum logic [1:0] {
      ST_DRAWN     = 2'd0,
      ST_NOT_SETUP = 2'd1,
      ST_LOAD_ACK  = 2'd2
   } status_type;

   typedef enum logic {
      FUNC_LOAD = 1'b0,
      FUNC_DRAW = 1'b1
   } func_type;

   typedef enum logic [2:0] {
      CSR_LINE_COUNT     = 3'd0,
      CSR_CONT_THRESHOLD = 3'd1,
      CSR_DIR_MODE       = 3'd2,
      CSR_FIX_X          = 3'd3,
      CSR_FIX_Y          = 3'd4,
      CSR_FIX_Z          = 3'd5
   } csr_index_type;

   localparam logic [1:0] DIR_ISOTROPIC = 2'd0;
   localparam logic [1:0] DIR_FIXED     = 2'd1;

   typedef struct packed {
      status_type                   status;
      logic                         from_cont;
      logic [LINE_BITS-1:0]         line_index;
      logic [ENERGY_BITS-1:0]       energy;
      logic signed [DIR_BITS-1:0]   dir_z;
   } side_type;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] z;
   } rot_type;

   typedef struct packed {
      logic [RAD_BITS-1:0] rem;
      logic [RAD_BITS-1:0] root;
   } root_type;

   function automatic rot_type cordic_step(rot_type a, int unsigned i,
                                           logic signed [CW-1:0] ang);
      rot_type o;
      if (!a.z[CW-1]) begin
         o.x = $signed(a.x) - ($signed(a.y) >>> i);
         o.y = $signed(a.y) + ($signed(a.x) >>> i);
         o.z = $signed(a.z) - ang;
      end else begin
         o.x = $signed(a.x) + ($signed(a.y) >>> i);
         o.y = $signed(a.y) - ($signed(a.x) >>> i);
         o.z = $signed(a.z) + ang;
      end
      return o;
   endfunction

   function automatic root_type sqrt_step(root_type a, int unsigned k);
      root_type            o;
      logic [RAD_BITS-1:0] b;
      logic [RAD_BITS:0]   t;
      b = RAD_BITS'(1) << (60 - 2 * k);
      t = {1'b0, a.root} + {1'b0, b};
      if ({1'b0, a.rem} >= t) begin
         o.rem  = a.rem - t[RAD_BITS-1:0];
         o.root = (a.root >> 1) + b;
      end else begin
         o.rem  = a.rem;
         o.root = a.root >> 1;
      end
      return o;
   endfunction

   function automatic logic signed [DIR_BITS-1:0] round_dir(
         logic signed [PROD_BITS-1:0] p);
      logic signed [PROD_BITS-1:0] t;
      logic signed [PROD_BITS-1:0] r;
      t = p + (PROD_BITS'(1) <<< (ROUND_SHIFT - 1));
      r = t >>> ROUND_SHIFT;
      if (r > (PROD_BITS'(1) <<< DIR_FRAC))
         r = PROD_BITS'(1) <<< DIR_FRAC;
      if (r < -(PROD_BITS'(1) <<< DIR_FRAC))
         r = -(PROD_BITS'(1) <<< DIR_FRAC);
      return r[DIR_BITS-1:0];
   endfunction

endpackage

FILE: rtl/pld_table.sv
module pld_table (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [pld_pkg::LINE_BITS-1:0]     wr_index,
   input  logic [pld_pkg::ENERGY_BITS-1:0]   wr_energy,
   input  logic [pld_pkg::CUM_BITS-1:0]      wr_cum,
   input  logic [pld_pkg::PROB_BITS-1:0]     pick,
   input  logic [pld_pkg::COUNT_BITS-1:0]    count,
   output logic [pld_pkg::LINE_BITS-1:0]     sel_index,
   output logic [pld_pkg::ENERGY_BITS-1:0]   sel_energy
);
   import pld_pkg::*;

   logic [ENERGY_BITS-1:0] energy_ff [MAX_LINES];
   logic [CUM_BITS-1:0]    thr_ff    [MAX_LINES];
   logic [COUNT_BITS-1:0]  used;
   logic                   found;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         energy_ff[wr_index] <= wr_energy;
         thr_ff[wr_index]    <= wr_cum;
      end
   end

   always_comb begin
      used      = (count > COUNT_BITS'(MAX_LINES)) ? COUNT_BITS'(MAX_LINES) : count;
      found     = 1'b0;
      sel_index = LINE_BITS'(used - COUNT_BITS'(1));
      for (int k = 0; k < MAX_LINES; k++) begin
         if (!found && (COUNT_BITS'(k) < used) && ({1'b0, pick} < thr_ff[k])) begin
            sel_index = LINE_BITS'(k);
            found     = 1'b1;
         end
      end
      sel_energy = energy_ff[sel_index];
   end

endmodule

FILE: rtl/pld_dir.sv
module pld_dir (
   input  logic                                   clock,
   input  logic                                   adv,
   input  logic signed [pld_pkg::UNI_BITS-1:0]    cos_in,
   input  logic [pld_pkg::UNI_BITS-1:0]           turn_in,
   output logic signed [pld_pkg::PROD_BITS-1:0]   prod_x,
   output logic signed [pld_pkg::PROD_BITS-1:0]   prod_y
);
   import pld_pkg::*;

   root_type                  root_ff [SQRT_STEPS+1];
   root_type                  root_in [SQRT_STEPS+1];
   rot_type                   rot_ff  [SQRT_STEPS+1];
   rot_type                   rot_in  [SQRT_STEPS+1];
   logic [1:0]                quad_ff [SQRT_STEPS+1];
   logic [1:0]                quad_in;
   logic signed [47:0]        csq;
   logic [46:0]               one_minus;
   logic [31:0]               ang;
   logic [31:0]               ang_rnd;
   logic [31:0]               ang_rd;
   logic signed [31:0]        s_val;
   logic signed [CW-1:0]      co;
   logic signed [CW-1:0]      si;
   logic signed [PROD_BITS-1:0] prod_x_ff;
   logic signed [PROD_BITS-1:0] prod_y_ff;

   always_comb begin
      csq          = cos_in * cos_in;
      one_minus    = (47'd1 << 46) - csq[46:0];
      root_in[0]   = '{rem: {one_minus, 14'd0}, root: '0};
      ang          = {turn_in, 8'd0};
      ang_rnd      = ang + 32'h2000_0000;
      quad_in      = ang_rnd[31:30];
      ang_rd       = ang - {quad_in, 30'd0};
      rot_in[0]    = '{x: CORDIC_GAIN, y: '0, z: {{2{ang_rd[31]}}, ang_rd}};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         root_ff[0] <= root_in[0];
         rot_ff[0]  <= rot_in[0];
         quad_ff[0] <= quad_in;
      end
   end

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
      if (k < CORDIC_STEPS) begin : g_rot
         always_comb rot_in[k+1] = cordic_step(rot_ff[k], k,
                                               $signed({2'b00, TURN_ATAN[k]}));
      end else begin : g_hold
         always_comb rot_in[k+1] = rot_ff[k];
      end
      always_comb root_in[k+1] = sqrt_step(root_ff[k], k);
      always_ff @(posedge clock) begin
         if (adv) begin
            root_ff[k+1] <= root_in[k+1];
            rot_ff[k+1]  <= rot_in[k+1];
            quad_ff[k+1] <= quad_ff[k];
         end
      end
   end

   always_comb begin
      s_val = $signed({1'b0, root_ff[SQRT_STEPS].root[30:0]});
      case (quad_ff[SQRT_STEPS])
         2'd0: begin
            co = rot_ff[SQRT_STEPS].x;
            si = rot_ff[SQRT_STEPS].y;
         end
         2'd1: begin
            co = -rot_ff[SQRT_STEPS].y;
            si = rot_ff[SQRT_STEPS].x;
         end
         2'd2: begin
            co = -rot_ff[SQRT_STEPS].x;
            si = -rot_ff[SQRT_STEPS].y;
         end
         default: begin
            co = rot_ff[SQRT_STEPS].y;
            si = -rot_ff[SQRT_STEPS].x;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_x_ff <= s_val * co;
         prod_y_ff <= s_val * si;
      end
   end

   assign prod_x = prod_x_ff;
   assign prod_y = prod_y_ff;

endmodule

FILE: rtl/photon_line_and_direction_sampler.sv
// Draws one photon per transaction: a line from the loaded table by inverse CDF (or the
// continuum flag) and a direction that is isotropic, fixed from the registers, or zero.
// A transaction may enter every cycle while the pipeline is not held; each result passes
// through the 31-step square root that runs beside the 30-step CORDIC rotation.
// The whole pipeline holds while a result waits on rsp_stall. Loads write the table in
// the second stage, so loads and draws take effect in the order they were accepted.
// Write the registers only while no transaction is in flight.
module photon_line_and_direction_sampler (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_func,
   input  logic [3:0]                            req_entry_index,
   input  logic [31:0]                           req_entry_energy,
   input  logic [24:0]                           req_entry_cum,
   input  logic [23:0]                           req_u_pick,
   input  logic signed [23:0]                    req_u_cos,
   input  logic [23:0]                           req_u_turn,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [31:0]                           rsp_energy,
   output logic                                  rsp_from_continuous,
   output logic [3:0]                            rsp_line_index,
   output logic signed [17:0]                    rsp_dir_x,
   output logic signed [17:0]                    rsp_dir_y,
   output logic signed [17:0]                    rsp_dir_z,
   output logic [1:0]                            rsp_status,
   input  logic                                  csr_wr_en,
   input  pld_pkg::csr_index_type                csr_index,
   input  logic [pld_pkg::CSR_BITS-1:0]          csr_wdata
);
   import pld_pkg::*;

   localparam int SIDE_LEN = SQRT_STEPS + 2;

   logic                         adv;
   logic                         vld0_ff;
   logic                         func_ff;
   logic [LINE_BITS-1:0]         idx_ff;
   logic [ENERGY_BITS-1:0]       entry_energy_ff;
   logic [CUM_BITS-1:0]          entry_cum_ff;
   logic [PROB_BITS-1:0]         pick_ff;
   logic signed [UNI_BITS-1:0]   cos_ff;
   logic [UNI_BITS-1:0]          turn_ff;

   logic [COUNT_BITS-1:0]        line_count_ff;
   logic [CUM_BITS-1:0]          cont_ff;
   logic [1:0]                   dir_mode_ff;
   logic signed [DIR_BITS-1:0]   fix_x_ff;
   logic signed [DIR_BITS-1:0]   fix_y_ff;
   logic signed [DIR_BITS-1:0]   fix_z_ff;

   logic                         tbl_wr;
   logic [LINE_BITS-1:0]         sel_index;
   logic [ENERGY_BITS-1:0]       sel_energy;
   logic                         cont_sel;
   logic                         not_setup;
   logic signed [UNI_BITS:0]     z_sum;
   side_type                     side_in;
   side_type                     side_ff [SIDE_LEN];
   logic                         vld_ff  [SIDE_LEN];
   logic signed [PROD_BITS-1:0]  prod_x;
   logic signed [PROD_BITS-1:0]  prod_y;

   side_type                     out_side;
   logic signed [DIR_BITS-1:0]   dx_in;
   logic signed [DIR_BITS-1:0]   dy_in;
   logic signed [DIR_BITS-1:0]   dz_in;

   logic                         rsp_valid_ff;
   logic [ENERGY_BITS-1:0]       rsp_energy_ff;
   logic                         rsp_cont_ff;
   logic [LINE_BITS-1:0]         rsp_line_ff;
   logic signed [DIR_BITS-1:0]   rsp_dx_ff;
   logic signed [DIR_BITS-1:0]   rsp_dy_ff;
   logic signed [DIR_BITS-1:0]   rsp_dz_ff;
   status_type                   rsp_status_ff;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_count_ff <= '0;
         cont_ff       <= '0;
         dir_mode_ff   <= '0;
         fix_x_ff      <= '0;
         fix_y_ff      <= '0;
         fix_z_ff      <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_LINE_COUNT:     line_count_ff <= csr_wdata[COUNT_BITS-1:0];
            CSR_CONT_THRESHOLD: cont_ff       <= csr_wdata[CUM_BITS-1:0];
            CSR_DIR_MODE:       dir_mode_ff   <= csr_wdata[1:0];
            CSR_FIX_X:          fix_x_ff      <= csr_wdata[DIR_BITS-1:0];
            CSR_FIX_Y:          fix_y_ff      <= csr_wdata[DIR_BITS-1:0];
            CSR_FIX_Z:          fix_z_ff      <= csr_wdata[DIR_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         vld0_ff <= 1'b0;
      else if (adv)
         vld0_ff <= req_valid;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         func_ff         <= req_func;
         idx_ff          <= req_entry_index;
         entry_energy_ff <= req_entry_energy;
         entry_cum_ff    <= req_entry_cum;
         pick_ff         <= req_u_pick;
         cos_ff          <= req_u_cos;
         turn_ff         <= req_u_turn;
      end
   end

   assign tbl_wr = adv && vld0_ff && (func_type'(func_ff) == FUNC_LOAD);

   pld_table u_table (
      .clock      (clock),
      .wr_en      (tbl_wr),
      .wr_index   (idx_ff),
      .wr_energy  (entry_energy_ff),
      .wr_cum     (entry_cum_ff),
      .pick       (pick_ff),
      .count      (line_count_ff),
      .sel_index  (sel_index),
      .sel_energy (sel_energy)
   );

   pld_dir u_dir (
      .clock   (clock),
      .adv     (adv),
      .cos_in  (cos_ff),
      .turn_in (turn_ff),
      .prod_x  (prod_x),
      .prod_y  (prod_y)
   );

   always_comb begin
      cont_sel  = {1'b0, pick_ff} < cont_ff;
      not_setup = (line_count_ff == '0) && !cont_sel;
      z_sum     = ({cos_ff[UNI_BITS-1], cos_ff} + (UNI_BITS+1)'(64)) >>> 7;
      side_in   = '0;
      if (func_type'(func_ff) == FUNC_LOAD) begin
         side_in.status = ST_LOAD_ACK;
      end else if (not_setup) begin
         side_in.status = ST_NOT_SETUP;
      end else begin
         side_in.status     = ST_DRAWN;
         side_in.from_cont  = cont_sel;
         side_in.line_index = cont_sel ? '0 : sel_index;
         side_in.energy     = cont_sel ? '0 : sel_energy;
         side_in.dir_z      = z_sum[DIR_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SIDE_LEN; k++)
            vld_ff[k] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= vld0_ff;
         for (int k = 1; k < SIDE_LEN; k++)
            vld_ff[k] <= vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= side_in;
         for (int k = 1; k < SIDE_LEN; k++)
            side_ff[k] <= side_ff[k-1];
      end
   end

   always_comb begin
      out_side = side_ff[SIDE_LEN-1];
      dx_in    = '0;
      dy_in    = '0;
      dz_in    = '0;
      if (out_side.status == ST_DRAWN) begin
         if (dir_mode_ff == DIR_ISOTROPIC) begin
            dx_in = round_dir(prod_x);
            dy_in = round_dir(prod_y);
            dz_in = out_side.dir_z;
         end else if (dir_mode_ff == DIR_FIXED) begin
            dx_in = fix_x_ff;
            dy_in = fix_y_ff;
            dz_in = fix_z_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (adv)
         rsp_valid_ff <= vld_ff[SIDE_LEN-1];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_energy_ff <= out_side.energy;
         rsp_cont_ff   <= out_side.from_cont;
         rsp_line_ff   <= out_side.line_index;
         rsp_dx_ff     <= dx_in;
         rsp_dy_ff     <= dy_in;
         rsp_dz_ff     <= dz_in;
         rsp_status_ff <= out_side.status;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_energy          = rsp_energy_ff;
   assign rsp_from_continuous = rsp_cont_ff;
   assign rsp_line_index      = rsp_line_ff;
   assign rsp_dir_x           = rsp_dx_ff;
   assign rsp_dir_y           = rsp_dy_ff;
   assign rsp_dir_z           = rsp_dz_ff;
   assign rsp_status          = rsp_status_ff;

`ifndef SYNTH
   a_nondraw_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_DRAWN) |->
         (rsp_energy == '0) && !rsp_from_continuous && (rsp_line_index == '0))
      else $error("non-draw transaction carries payload");

   a_cont_no_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_from_continuous |->
         (rsp_energy == '0) && (rsp_line_index == '0) && (rsp_status == ST_DRAWN))
      else $error("continuum transaction carries a line");

   a_load_no_dir: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_LOAD_ACK) |->
         (rsp_dir_x == '0) && (rsp_dir_y == '0) && (rsp_dir_z == '0))
      else $error("load acknowledge carries a direction");
`endif

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps

module tb;
   import pld_pkg::*;

   typedef struct {
      logic [31:0]         energy;
      logic                from_cont;
      logic [3:0]          line_index;
      logic signed [17:0]  dx;
      logic signed [17:0]  dy;
      logic signed [17:0]  dz;
      status_type          status;
   } photon_type;

   class photon_scoreboard;
      logic [31:0] energy_tab [16];
      logic [24:0] cum_tab [16];
      logic [4:0]  line_count;
      logic [24:0] cont_thr;
      logic [1:0]  dir_mode;
      logic signed [17:0] fix_x, fix_y, fix_z;
      photon_type  pending_q [$];
      int          errors;
      longint      atan_tab [30] = '{
         536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
         10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
         83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
         81, 41, 20, 10, 5, 3, 1};

      function new();
         line_count = 0; cont_thr = 0; dir_mode = 0;
         fix_x = 0; fix_y = 0; fix_z = 0;
         errors = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [24:0] v);
         case (idx)
            CSR_LINE_COUNT:     line_count = v[4:0];
            CSR_CONT_THRESHOLD: cont_thr = v;
            CSR_DIR_MODE:       dir_mode = v[1:0];
            CSR_FIX_X:          fix_x = v[17:0];
            CSR_FIX_Y:          fix_y = v[17:0];
            CSR_FIX_Z:          fix_z = v[17:0];
            default: ;
         endcase
      endfunction

      function logic signed [17:0] dir_round(longint p);
         longint r;
         r = (p + (64'sd1 <<< 43)) >>> 44;
         if (r > 65536) r = 65536;
         if (r < -65536) r = -65536;
         return r[17:0];
      endfunction

      function longint unsigned root60(longint unsigned v);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > v) b = b >> 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      function void turn_cos_sin(logic [23:0] t, output longint co, output longint si);
         logic [31:0] a, q, rd;
         longint x, y, z, nx;
         a = {t, 8'h00};
         q = (a + 32'h2000_0000) >> 30;
         rd = a - (q << 30);
         z = longint'($signed(rd));
         x = 652032874;
         y = 0;
         for (int i = 0; i < 30; i++) begin
            if (z >= 0) begin
               nx = x - (y >>> i);
               y = y + (x >>> i);
               z = z - atan_tab[i];
            end else begin
               nx = x + (y >>> i);
               y = y - (x >>> i);
               z = z + atan_tab[i];
            end
            x = nx;
         end
         case (q[1:0])
            2'd0: begin co = x; si = y; end
            2'd1: begin co = -y; si = x; end
            2'd2: begin co = -x; si = -y; end
            default: begin co = y; si = -x; end
         endcase
      endfunction

      function void note_request(logic f, logic [3:0] ei, logic [31:0] en,
                                 logic [24:0] cum, logic [23:0] up,
                                 logic [23:0] uc, logic [23:0] ut);
         photon_type e;
         int n, sel;
         longint c, s, co, si;
         longint unsigned v;
         e = '{energy: 0, from_cont: 0, line_index: 0, dx: 0, dy: 0, dz: 0,
               status: ST_DRAWN};
         n = (line_count > 16) ? 16 : line_count;
         if (f == FUNC_LOAD) begin
            energy_tab[ei] = en;
            cum_tab[ei] = cum;
            e.status = ST_LOAD_ACK;
         end else if (n == 0 && (cont_thr == 0 || up >= cont_thr)) begin
            e.status = ST_NOT_SETUP;
         end else begin
            if (dir_mode == DIR_ISOTROPIC) begin
               c = longint'($signed(uc));
               v = (64'd1 << 46) - longint'(c * c);
               s = root60(v << 14);
               turn_cos_sin(ut, co, si);
               e.dx = dir_round(s * co);
               e.dy = dir_round(s * si);
               e.dz = dir_round(c * (64'sd1 <<< 37));
            end else if (dir_mode == DIR_FIXED) begin
               e.dx = fix_x; e.dy = fix_y; e.dz = fix_z;
            end
            if (up < cont_thr) begin
               e.from_cont = 1;
            end else begin
               sel = n - 1;
               for (int k = n - 1; k >= 0; k--)
                  if (up < cum_tab[k]) sel = k;
               e.energy = energy_tab[sel];
               e.line_index = 4'(sel);
            end
         end
         pending_q.insert(pending_q.size(), e);
      endfunction

      task report(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_response(photon_type g);
         photon_type e;
         if (pending_q.size() == 0) begin
            report("result with no transaction outstanding");
            return;
         end
         e = pending_q.pop_front();
         if (g.status !== e.status)
            report($sformatf("status %0d, want %0d", g.status, e.status));
         if (g.energy !== e.energy)
            report($sformatf("energy %h, want %h", g.energy, e.energy));
         if (g.from_cont !== e.from_cont)
            report($sformatf("from_continuous %b, want %b", g.from_cont, e.from_cont));
         if (g.line_index !== e.line_index)
            report($sformatf("line_index %0d, want %0d", g.line_index, e.line_index));
         if (g.dx !== e.dx) report($sformatf("dir_x %0d, want %0d", g.dx, e.dx));
         if (g.dy !== e.dy) report($sformatf("dir_y %0d, want %0d", g.dy, e.dy));
         if (g.dz !== e.dz) report($sformatf("dir_z %0d, want %0d", g.dz, e.dz));
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic req_func = 0;
   logic [3:0] req_entry_index = 0;
   logic [31:0] req_entry_energy = 0;
   logic [24:0] req_entry_cum = 0;
   logic [23:0] req_u_pick = 0;
   logic signed [23:0] req_u_cos = 0;
   logic [23:0] req_u_turn = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [31:0] rsp_energy;
   logic rsp_from_continuous;
   logic [3:0] rsp_line_index;
   logic signed [17:0] rsp_dir_x, rsp_dir_y, rsp_dir_z;
   logic [1:0] rsp_status;
   logic csr_wr_en = 0;
   csr_index_type csr_index = CSR_LINE_COUNT;
   logic [CSR_BITS-1:0] csr_wdata = 0;

   photon_scoreboard sb = new();
   bit idle_on = 1;
   bit hold_off_req = 0;
   int sent = 0;

   photon_line_and_direction_sampler dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_request(req_func, req_entry_index, req_entry_energy, req_entry_cum,
                            req_u_pick, req_u_cos, req_u_turn);
         if (rsp_valid && !rsp_stall)
            sb.check_response('{energy: rsp_energy, from_cont: rsp_from_continuous,
                                line_index: rsp_line_index, dx: rsp_dir_x,
                                dy: rsp_dir_y, dz: rsp_dir_z,
                                status: status_type'(rsp_status)});
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 0;
            rsp_stall <= 1;
            repeat (200) @(posedge clock);
         end
         rsp_stall <= idle_on && ($urandom_range(0, 99) < 19);
      end
   end

   initial begin
      #20ms;
      $display("*** FAILED ***");
      $finish;
   end

   task automatic send(logic f, logic [3:0] ei, logic [31:0] en, logic [24:0] cum,
                       logic [23:0] up, logic [23:0] uc, logic [23:0] ut);
      bit go;
      if (idle_on && $urandom_range(0, 99) < 19) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1;
      req_func <= f;
      req_entry_index <= ei;
      req_entry_energy <= en;
      req_entry_cum <= cum;
      req_u_pick <= up;
      req_u_cos <= uc;
      req_u_turn <= ut;
      forever begin
         @(negedge clock);
         go = !req_stall;
         @(posedge clock);
         if (go) break;
      end
      sent++;
   endtask

   task automatic send_random();
      if ($urandom_range(0, 99) < 15)
         send(FUNC_LOAD, 4'($urandom), $urandom, 25'($urandom_range(0, 16777216)),
              24'($urandom), 24'($urandom), 24'($urandom));
      else
         send(FUNC_DRAW, 4'($urandom), $urandom, 25'($urandom), 24'($urandom),
              24'($urandom), 24'($urandom));
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [24:0] v);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wdata <= v;
      sb.set_reg(idx, v);
      @(posedge clock);
   endtask

   task automatic setup(logic [4:0] lc, logic [24:0] ct, logic [1:0] dm,
                        logic signed [17:0] fx, logic signed [17:0] fy,
                        logic signed [17:0] fz);
      drain();
      write_reg(CSR_LINE_COUNT, lc);
      write_reg(CSR_CONT_THRESHOLD, ct);
      write_reg(CSR_DIR_MODE, dm);
      write_reg(CSR_FIX_X, 25'(fx));
      write_reg(CSR_FIX_Y, 25'(fy));
      write_reg(CSR_FIX_Z, 25'(fz));
      csr_wr_en <= 0;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send(FUNC_DRAW, 0, 0, 0, 24'hFFFFFF, 0, 0);
      for (int i = 0; i < 16; i++)
         send(FUNC_LOAD, 4'(i), (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFFFFFF : $urandom,
              (i == 15) ? 25'd16777216 : (i == 0) ? 25'd0 : 25'(i * 1048576), 0, 0, 0);

      setup(16, 0, DIR_ISOTROPIC, 0, 0, 0);
      send(FUNC_DRAW, 0, 0, 0, 24'd0, 24'h800000, 24'd0);
      send(FUNC_DRAW, 0, 0, 0, 24'hFFFFFF, 24'h7FFFFF, 24'hFFFFFF);
      send(FUNC_DRAW, 0, 0, 0, 24'd1048576, 24'd0, 24'h400000);
      send(FUNC_DRAW, 0, 0, 0, 24'd5000000, 24'h000001, 24'h200000);
      send(FUNC_DRAW, 0, 0, 0, 24'd8000000, 24'hFFFFFF, 24'h800000);
      send(FUNC_DRAW, 0, 0, 0, 24'd12000000, 24'h400000, 24'hC00000);

      setup(1, 25'd16777216, DIR_FIXED, 18'sd65536, -18'sd65536, 0);
      send(FUNC_DRAW, 0, 0, 0, 24'hFFFFFF, 0, 0);
      repeat (40) send_random();

      setup(31, 25'h400000, DIR_ISOTROPIC, 0, 0, 0);
      hold_off_req = 1;
      repeat (80) send_random();

      setup(0, 25'h800000, 2'd2, 18'sd100, 18'sd200, 18'sd300);
      repeat (40) send_random();

      setup(0, 0, DIR_FIXED, 18'sd1, 18'sd2, 18'sd3);
      repeat (10) send_random();

      idle_on = 0;
      setup(5, 25'($urandom_range(0, 16777216)), 2'd3, 0, 0, 0);
      repeat (60) send_random();
      idle_on = 1;

      while (sent < 560) begin
         setup(5'($urandom),
               25'($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16777216)),
               2'($urandom_range(0, 3)), 18'($urandom_range(0, 131072) - 65536),
               18'($urandom_range(0, 131072) - 65536),
               18'($urandom_range(0, 131072) - 65536));
         repeat (60) send_random();
      end

      drain();
      if (sb.errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule
